// ===== rtl/integer_to_text_formatter_defines.svh =====
// Assertion helpers for the integer-to-text formatter.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// Check that holds in the same cycle as the trigger.
`define ITF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter check failed");

// Check that holds in the cycle after the trigger.
`define ITF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter check failed");

`endif

// ===== rtl/itf_pkg.sv =====
`default_nettype none

package itf_pkg;

    localparam int ITF_VALUE_BITS = 32;
    localparam int ITF_MAX_CHARS  = 64;
    localparam int ITF_MAX_PREC   = 61;
    localparam int ITF_ADDR_W     = 5;
    localparam int ITF_DATA_W     = 32;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_BASE_SELECT  = 3'd0;
    localparam logic [2:0] REG_UPPER_CASE   = 3'd1;
    localparam logic [2:0] REG_LEFT_JUSTIFY = 3'd2;
    localparam logic [2:0] REG_SIGN_MODE    = 3'd3;
    localparam logic [2:0] REG_ALT_FORM     = 3'd4;
    localparam logic [2:0] REG_ZERO_FILL    = 3'd5;
    localparam logic [2:0] REG_FIELD_WIDTH  = 3'd6;
    localparam logic [2:0] REG_MIN_DIGITS   = 3'd7;

    // Radix codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    // Sign modes for non-negative values
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    // ASCII characters
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_B = 8'h42;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic [1:0] base_select;
        logic       upper_case;
        logic       left_justify;
        logic [1:0] sign_mode;
        logic       alt_form;
        logic       zero_fill;
        logic [6:0] field_width;
        logic [5:0] min_digits;
    } itf_cfg_t;

    // Commands from the sequencer to the digit unit
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [1:0] base_select;
    } itf_conv_cmd_t;

    function automatic logic [4:0] itf_radix(input logic [1:0] sel);
        logic [4:0] r;
        unique case (sel)
            BASE_BIN: r = 5'd2;
            BASE_OCT: r = 5'd8;
            BASE_DEC: r = 5'd10;
            BASE_HEX: r = 5'd16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] itf_digit_char(input logic [3:0] d, input logic uc);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'b0000, d};
        end else begin
            c = (uc ? CH_UPPER_A : CH_LOWER_A) + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/itf_cfg_regs.sv =====
`default_nettype none

module itf_cfg_regs
    import itf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ITF_ADDR_W-1:0] paddr,
    input  wire logic [ITF_DATA_W-1:0] pwdata,
    output logic      [ITF_DATA_W-1:0] prdata,
    output logic                       pready,
    output itf_cfg_t                   cfg
);

    itf_cfg_t   cfg_reg;
    itf_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ITF_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Update the addressed register on the access beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_BASE_SELECT:  cfg_next.base_select  = pwdata[1:0];
                REG_UPPER_CASE:   cfg_next.upper_case   = pwdata[0];
                REG_LEFT_JUSTIFY: cfg_next.left_justify = pwdata[0];
                REG_SIGN_MODE:    cfg_next.sign_mode    = pwdata[1:0];
                REG_ALT_FORM:     cfg_next.alt_form     = pwdata[0];
                REG_ZERO_FILL:    cfg_next.zero_fill    = pwdata[0];
                REG_FIELD_WIDTH:  cfg_next.field_width  = pwdata[6:0];
                REG_MIN_DIGITS:   cfg_next.min_digits   = pwdata[5:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_select  <= BASE_DEC;
            cfg_reg.upper_case   <= 1'b0;
            cfg_reg.left_justify <= 1'b0;
            cfg_reg.sign_mode    <= SIGN_NONE;
            cfg_reg.alt_form     <= 1'b0;
            cfg_reg.zero_fill    <= 1'b0;
            cfg_reg.field_width  <= 7'd0;
            cfg_reg.min_digits   <= 6'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_BASE_SELECT:  prdata = ITF_DATA_W'(cfg_reg.base_select);
            REG_UPPER_CASE:   prdata = ITF_DATA_W'(cfg_reg.upper_case);
            REG_LEFT_JUSTIFY: prdata = ITF_DATA_W'(cfg_reg.left_justify);
            REG_SIGN_MODE:    prdata = ITF_DATA_W'(cfg_reg.sign_mode);
            REG_ALT_FORM:     prdata = ITF_DATA_W'(cfg_reg.alt_form);
            REG_ZERO_FILL:    prdata = ITF_DATA_W'(cfg_reg.zero_fill);
            REG_FIELD_WIDTH:  prdata = ITF_DATA_W'(cfg_reg.field_width);
            REG_MIN_DIGITS:   prdata = ITF_DATA_W'(cfg_reg.min_digits);
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/itf_digit_conv.sv =====
`default_nettype none

// Radix conversion unit. The magnitude is shifted in MSB first, one bit per
// cycle; every digit doubles and takes the carry of the digit below it. The
// carry out of a digit depends only on that digit (d >= radix/2), so all
// digits update side by side with no ripple. Afterwards the digit string
// shifts up one digit per command and the top digit is read out.
module itf_digit_conv
    import itf_pkg::*;
#(
    parameter  int VALUE_BITS = ITF_VALUE_BITS,
    localparam int NDW        = $clog2(VALUE_BITS + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire itf_conv_cmd_t         cmd,
    input  wire logic [VALUE_BITS-1:0] mag,
    output logic                       done,
    output logic      [NDW-1:0]        ndig,
    output logic      [3:0]            top_digit
);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [3:0]            dig_reg  [VALUE_BITS];
    logic [3:0]            dig_next [VALUE_BITS];
    logic [3:0]            dig_step [VALUE_BITS];
    logic [VALUE_BITS-1:0] ge;
    logic [VALUE_BITS-1:0] nz;
    logic [VALUE_BITS-1:0] live_reg;
    logic [VALUE_BITS-1:0] live_next;
    logic [NDW-1:0]        ndig_reg;
    logic [NDW-1:0]        ndig_next;
    logic [NDW-1:0]        step_reg;
    logic [NDW-1:0]        step_next;
    logic                  active_reg;
    logic                  active_next;
    logic [4:0]            radix;
    logic [3:0]            half;

    assign radix     = itf_radix(cmd.base_select);
    assign half      = radix[4:1];
    assign done      = active_reg && (step_reg == NDW'(1));
    assign ndig      = ndig_reg;
    assign top_digit = dig_reg[VALUE_BITS-1];

    // Double every digit and add the carry from below
    always_comb
    begin
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            ge[i] = (dig_reg[i] >= half);
        end
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (i == 0)
            begin
                dig_step[i] = 4'({dig_reg[i], mag_reg[VALUE_BITS-1]}
                                 - (ge[i] ? radix : 5'd0));
            end
            else
            begin
                dig_step[i] = 4'({dig_reg[i], ge[i-1]} - (ge[i] ? radix : 5'd0));
            end
            nz[i] = (dig_step[i] != 4'd0);
        end
    end

    // Load, step, or shift the digit string up
    always_comb
    begin
        mag_next    = mag_reg;
        dig_next    = dig_reg;
        live_next   = live_reg;
        ndig_next   = ndig_reg;
        step_next   = step_reg;
        active_next = active_reg;
        if (cmd.load)
        begin
            mag_next = mag;
            for (int i = 0; i < VALUE_BITS; i++)
            begin
                dig_next[i] = 4'd0;
            end
            live_next   = '0;
            ndig_next   = '0;
            step_next   = NDW'(VALUE_BITS);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            mag_next  = mag_reg << 1;
            dig_next  = dig_step;
            live_next = live_reg | nz;
            // At most one new leading digit appears per step
            ndig_next = ndig_reg + NDW'(|(nz & ~live_reg));
            step_next = step_reg - NDW'(1);
            if (step_reg == NDW'(1))
            begin
                active_next = 1'b0;
            end
        end
        else if (cmd.shift)
        begin
            dig_next[0] = 4'd0;
            for (int i = 1; i < VALUE_BITS; i++)
            begin
                dig_next[i] = dig_reg[i-1];
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    // Hold the working value and digits
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        live_reg <= live_next;
        ndig_reg <= ndig_next;
    end

endmodule

`default_nettype wire

// ===== rtl/integer_to_text_formatter.sv =====
// Sequence: conversion of the magnitude one bit per cycle, a layout step, align
// shifts when the precision is below VALUE_BITS, then the character phases,
// each character passing through the output register. Busy holds off the
// next item until the final character beat. The receiver cannot stall: each
// character shows for one cycle.
// Reset loads default configuration and returns the sequencer to idle.
`default_nettype none

module integer_to_text_formatter
    import itf_pkg::*;
#(
    parameter int VALUE_BITS = ITF_VALUE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  is_signed,
    output logic                       text_valid,
    output logic      [7:0]            text_char,
    output logic                       last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ITF_ADDR_W-1:0] paddr,
    input  wire logic [ITF_DATA_W-1:0] pwdata,
    output logic      [ITF_DATA_W-1:0] prdata,
    output logic                       pready
);

`include "integer_to_text_formatter_defines.svh"

    localparam int NDW = $clog2(VALUE_BITS + 1);
    localparam int CW  = $clog2(ITF_MAX_CHARS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_LAYOUT,
        S_ALIGN,
        S_LPAD,
        S_SIGN,
        S_PFX0,
        S_PFX1,
        S_ZPAD,
        S_DIG,
        S_RPAD
    } state_t;

    itf_cfg_t              cfg;
    itf_conv_cmd_t         conv_cmd;
    logic                  conv_done;
    logic [NDW-1:0]        conv_ndig;
    logic [3:0]            top_digit;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  shift_cmd;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  left_reg, left_next;
    logic [CW-1:0]  prec_reg, prec_next;
    logic [CW-1:0]  pad_reg, pad_next;
    logic           neg_reg, neg_next;
    logic           sgn_reg, sgn_next;
    logic [7:0]     sch_reg, sch_next;
    logic           pfx_reg, pfx_next;
    logic           text_valid_reg, text_valid_next;
    logic [7:0]     text_char_reg, text_char_next;
    logic           last_reg, last_next;

    logic           oct_extra;
    logic [CW-1:0]  ndig_eff;
    logic [CW-1:0]  prec_cfg;
    logic [CW-1:0]  prec_l;
    logic [CW-1:0]  len_l;
    logic [CW-1:0]  width_l;
    logic [CW-1:0]  pad_l;
    logic [CW-1:0]  total_l;
    logic           pfx_l;
    logic           sgn_l;
    logic [7:0]     sch_l;
    logic           emit;
    logic [7:0]     emit_ch;

    itf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    itf_digit_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (conv_cmd),
        .mag       (in_mag),
        .done      (conv_done),
        .ndig      (conv_ndig),
        .top_digit (top_digit)
    );

    // Take the magnitude of the incoming value
    assign in_neg = is_signed && value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

    assign busy                 = (state_reg != S_IDLE);
    assign conv_cmd.load        = start && (state_reg == S_IDLE);
    assign conv_cmd.shift       = shift_cmd;
    assign conv_cmd.base_select = cfg.base_select;

    assign text_valid = text_valid_reg;
    assign text_char  = text_char_reg;
    assign last       = last_reg;

    // Lay out the field once the digit count is known
    always_comb
    begin
        oct_extra = cfg.alt_form && (cfg.base_select == BASE_OCT)
                    && (conv_ndig != NDW'(0));
        ndig_eff  = CW'(conv_ndig) + CW'(oct_extra);
        prec_cfg  = (cfg.min_digits > 6'(ITF_MAX_PREC)) ? CW'(ITF_MAX_PREC)
                                                        : CW'(cfg.min_digits);
        prec_l    = (ndig_eff > prec_cfg) ? ndig_eff : prec_cfg;
        pfx_l     = cfg.alt_form
                    && ((cfg.base_select == BASE_HEX) || (cfg.base_select == BASE_BIN));
        sgn_l     = neg_reg || (cfg.sign_mode == SIGN_PLUS)
                    || (cfg.sign_mode == SIGN_SPACE);
        sch_l     = neg_reg ? CH_MINUS
                    : ((cfg.sign_mode == SIGN_PLUS) ? CH_PLUS : CH_SPACE);
        len_l     = prec_l + (pfx_l ? CW'(2) : CW'(0)) + CW'(sgn_l);
        width_l   = (cfg.field_width > CW'(ITF_MAX_CHARS)) ? CW'(ITF_MAX_CHARS)
                                                           : cfg.field_width;
        pad_l     = (width_l > len_l) ? (width_l - len_l) : CW'(0);
        total_l   = pad_l + len_l;
    end

    // Sequence the phases and pick the character for this beat
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        prec_next  = prec_reg;
        pad_next   = pad_reg;
        neg_next   = neg_reg;
        sgn_next   = sgn_reg;
        sch_next   = sch_reg;
        pfx_next   = pfx_reg;
        emit       = 1'b0;
        emit_ch    = CH_ZERO;
        shift_cmd  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next   = in_neg;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = S_LAYOUT;
                end
            end
            S_LAYOUT:
            begin
                prec_next = prec_l;
                pad_next  = pad_l;
                sgn_next  = sgn_l;
                sch_next  = sch_l;
                pfx_next  = pfx_l;
                left_next = total_l;
                // Bring digit prec-1 to the top of the digit string
                cnt_next  = (prec_l < CW'(VALUE_BITS)) ? (CW'(VALUE_BITS) - prec_l)
                                                       : CW'(0);
                state_next = (total_l == CW'(0)) ? S_IDLE : S_ALIGN;
            end
            S_ALIGN:
            begin
                if (cnt_reg != CW'(0))
                begin
                    shift_cmd = 1'b1;
                    cnt_next  = cnt_reg - CW'(1);
                end
                else
                begin
                    cnt_next   = (!cfg.left_justify && !cfg.zero_fill) ? pad_reg : CW'(0);
                    state_next = S_LPAD;
                end
            end
            S_LPAD:
            begin
                if (cnt_reg != CW'(0))
                begin
                    emit     = 1'b1;
                    emit_ch  = CH_SPACE;
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                emit       = sgn_reg;
                emit_ch    = sch_reg;
                state_next = S_PFX0;
            end
            S_PFX0:
            begin
                emit       = pfx_reg;
                emit_ch    = CH_ZERO;
                state_next = S_PFX1;
            end
            S_PFX1:
            begin
                emit = pfx_reg;
                if (cfg.base_select == BASE_HEX)
                begin
                    emit_ch = cfg.upper_case ? CH_UPPER_X : CH_LOWER_X;
                end
                else
                begin
                    emit_ch = cfg.upper_case ? CH_UPPER_B : CH_LOWER_B;
                end
                cnt_next   = (!cfg.left_justify && cfg.zero_fill) ? pad_reg : CW'(0);
                state_next = S_ZPAD;
            end
            S_ZPAD:
            begin
                if (cnt_reg != CW'(0))
                begin
                    emit     = 1'b1;
                    emit_ch  = CH_ZERO;
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    cnt_next   = prec_reg;
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (cnt_reg != CW'(0))
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                    // Digits above the conversion width are leading zeros
                    if (cnt_reg > CW'(VALUE_BITS))
                    begin
                        emit_ch = CH_ZERO;
                    end
                    else
                    begin
                        emit_ch   = itf_digit_char(top_digit, cfg.upper_case);
                        shift_cmd = 1'b1;
                    end
                end
                else
                begin
                    cnt_next   = cfg.left_justify ? pad_reg : CW'(0);
                    state_next = S_RPAD;
                end
            end
            S_RPAD:
            begin
                if (cnt_reg != CW'(0))
                begin
                    emit     = 1'b1;
                    emit_ch  = CH_SPACE;
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Count down the characters; drop back to idle after the final one
        if (emit)
        begin
            left_next = left_reg - CW'(1);
            if (left_reg == CW'(1))
            begin
                state_next = S_IDLE;
            end
        end

        text_valid_next = emit;
        text_char_next  = emit_ch;
        last_next       = emit && (left_reg == CW'(1));
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            left_reg       <= '0;
            text_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            prec_reg       <= '0;
            pad_reg        <= '0;
            neg_reg        <= 1'b0;
            sgn_reg        <= 1'b0;
            sch_reg        <= CH_SPACE;
            pfx_reg        <= 1'b0;
            text_char_reg  <= CH_SPACE;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            left_reg       <= left_next;
            text_valid_reg <= text_valid_next;
            last_reg       <= last_next;
            prec_reg       <= prec_next;
            pad_reg        <= pad_next;
            neg_reg        <= neg_next;
            sgn_reg        <= sgn_next;
            sch_reg        <= sch_next;
            pfx_reg        <= pfx_next;
            text_char_reg  <= text_char_next;
        end
    end

    // The final beat frees the block; any earlier beat keeps it busy
    `ITF_ASSERT_NOW(a_last_frees, text_valid && last, !busy)
    `ITF_ASSERT_NOW(a_mid_busy, text_valid && !last, busy)
    // An accepted item starts work at once
    `ITF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // No beat directly follows the final one
    `ITF_ASSERT_NEXT(a_last_gap, text_valid && last, !text_valid)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itf_pkg::*;

    localparam int         DRAIN_CYCLES    = 160;
    localparam int         CYCLE_LIMIT     = 1_000_000;
    localparam int         RANDOM_PHASES   = 12;
    localparam int         ITEMS_PER_PHASE = 38;
    localparam logic [1:0] SIGN_UNUSED     = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [31:0]           value     = '0;
    logic                  is_signed = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ITF_ADDR_W-1:0] paddr     = '0;
    logic [ITF_DATA_W-1:0] pwdata    = '0;
    logic                  busy;
    logic                  text_valid;
    logic [7:0]            text_char;
    logic                  last;
    logic [ITF_DATA_W-1:0] prdata;
    logic                  pready;

    // Format currently loaded in the block
    itf_cfg_t   fmt;
    int         idle_pct    = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    text_beat_t expected_text[$];

    always #5 clk = ~clk;

    integer_to_text_formatter #(
        .VALUE_BITS (ITF_VALUE_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .is_signed  (is_signed),
        .text_valid (text_valid),
        .text_char  (text_char),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Lay out the text of one number and queue its characters
    function automatic void predict_text(input logic [31:0] v, input logic sgn);
        logic [31:0] mag;
        logic [31:0] t;
        logic        neg;
        logic [4:0]  radix;
        logic        has_sign;
        logic        has_prefix;
        logic [7:0]  sign_ch;
        logic [3:0]  d;
        logic [3:0]  digs [ITF_MAX_CHARS];
        logic [7:0]  text[$];
        int          ndig;
        int          prec;
        int          width;
        int          len;
        int          pad;
        text_beat_t  beat;

        neg = sgn && v[31];
        // most negative value wraps onto 2^31, which is the magnitude
        mag = neg ? (~v + 32'd1) : v;
        case (fmt.base_select)
            BASE_BIN: radix = 5'd2;
            BASE_OCT: radix = 5'd8;
            BASE_DEC: radix = 5'd10;
            default:  radix = 5'd16;
        endcase
        width = (fmt.field_width > ITF_MAX_CHARS) ? ITF_MAX_CHARS : fmt.field_width;
        prec  = (fmt.min_digits > ITF_MAX_PREC) ? ITF_MAX_PREC : fmt.min_digits;

        // count significant digits; octal alternate form adds a leading zero
        ndig = 0;
        for (t = mag; t != 0; t = t / radix)
            ndig++;
        if (fmt.alt_form && fmt.base_select == BASE_OCT && mag != 0)
            ndig++;
        if (ndig > prec)
            prec = ndig;

        has_prefix = fmt.alt_form && (fmt.base_select == BASE_HEX || fmt.base_select == BASE_BIN);
        has_sign   = neg || fmt.sign_mode == SIGN_PLUS || fmt.sign_mode == SIGN_SPACE;
        sign_ch    = neg ? CH_MINUS : ((fmt.sign_mode == SIGN_PLUS) ? CH_PLUS : CH_SPACE);
        len        = prec + (has_prefix ? 2 : 0) + (has_sign ? 1 : 0);
        pad        = (width > len) ? width - len : 0;

        t = mag;
        for (int i = 0; i < prec; i++)
        begin
            digs[i] = 4'(t % radix);
            t       = t / radix;
        end

        // assemble: pad, sign, prefix, zero fill, digits, trailing pad
        if (!fmt.left_justify && !fmt.zero_fill)
            repeat (pad) text.push_back(CH_SPACE);
        if (has_sign)
            text.push_back(sign_ch);
        if (has_prefix)
        begin
            text.push_back(CH_ZERO);
            if (fmt.base_select == BASE_HEX)
                text.push_back(fmt.upper_case ? CH_UPPER_X : CH_LOWER_X);
            else
                text.push_back(fmt.upper_case ? CH_UPPER_B : CH_LOWER_B);
        end
        if (!fmt.left_justify && fmt.zero_fill)
            repeat (pad) text.push_back(CH_ZERO);
        for (int i = prec; i > 0; i--)
        begin
            d = digs[i-1];
            if (d < 4'd10)
                text.push_back(CH_ZERO + {4'd0, d});
            else
                text.push_back((fmt.upper_case ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10);
        end
        if (fmt.left_justify)
            repeat (pad) text.push_back(CH_SPACE);

        while (text.size() > ITF_MAX_CHARS)
            void'(text.pop_back());
        foreach (text[i])
        begin
            beat.ch   = text[i];
            beat.last = (i == text.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    // Compare every character beat against the oldest expectation
    always @(posedge clk)
    begin : check_text
        text_beat_t want;
        if (rst_n && text_valid)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected character beat: text_char=%h last=%b", text_char, last);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_char !== want.ch)
                begin
                    $error("text_char mismatch: expected %h, got %h", want.ch, text_char);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %b, got %b", want.last, last);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drop start, drain the text, then let a silent item finish
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // A setup phase, then an access phase held until pready, per register write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_format(input logic [1:0] base, input logic uc, input logic lj,
                              input logic [1:0] sm, input logic alt, input logic zp,
                              input logic [6:0] fw, input logic [5:0] md);
        wait_idle();
        write_reg(REG_BASE_SELECT, {30'd0, base});
        write_reg(REG_UPPER_CASE, {31'd0, uc});
        write_reg(REG_LEFT_JUSTIFY, {31'd0, lj});
        write_reg(REG_SIGN_MODE, {30'd0, sm});
        write_reg(REG_ALT_FORM, {31'd0, alt});
        write_reg(REG_ZERO_FILL, {31'd0, zp});
        write_reg(REG_FIELD_WIDTH, {25'd0, fw});
        write_reg(REG_MIN_DIGITS, {26'd0, md});
        fmt.base_select  = base;
        fmt.upper_case   = uc;
        fmt.left_justify = lj;
        fmt.sign_mode    = sm;
        fmt.alt_form     = alt;
        fmt.zero_fill    = zp;
        fmt.field_width  = fw;
        fmt.min_digits   = md;
    endtask

    // Hold start until the block takes the number, then maybe go quiet
    task automatic send_number(input logic [31:0] v, input logic sgn);
        int gap;
        start     <= 1'b1;
        value     <= v;
        is_signed <= sgn;
        do
            @(posedge clk);
        while (busy);
        predict_text(v, sgn);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = ($urandom_range(1) == 1) ? $urandom_range(1, 6) : $urandom_range(7, 150);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return $urandom() >> $urandom_range(31);
            2:
            begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            3: return 32'd0 - 32'($urandom_range(1, 300));
            default: return $urandom();
        endcase
    endfunction

    task automatic test_reset_format();
        send_number(32'h0000_0000, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_radix_and_prefix();
        set_format(BASE_HEX, 1'b1, 1'b0, SIGN_PLUS, 1'b1, 1'b1, 7'd12, 6'd1);
        send_number(32'hDEAD_BEEF, 1'b0);
        send_number(32'h0000_0000, 1'b0);
        // prefix stays on a zero with no digits
        set_format(BASE_BIN, 1'b0, 1'b0, SIGN_NONE, 1'b1, 1'b0, 7'd0, 6'd0);
        send_number(32'h0000_0000, 1'b0);
        send_number(32'h0000_0005, 1'b0);
        // octal leading zero only when the digits fill the precision
        set_format(BASE_OCT, 1'b0, 1'b0, SIGN_NONE, 1'b1, 1'b0, 7'd0, 6'd1);
        send_number(32'h0000_0008, 1'b0);
        send_number(32'h0000_0000, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);
        set_format(BASE_OCT, 1'b1, 1'b0, SIGN_NONE, 1'b1, 1'b0, 7'd0, 6'd4);
        send_number(32'h0000_0007, 1'b0);
    endtask

    task automatic test_zero_and_empty();
        set_format(BASE_DEC, 1'b0, 1'b0, SIGN_NONE, 1'b0, 1'b0, 7'd0, 6'd0);
        send_number(32'h0000_0000, 1'b0);
        send_number(32'h0000_0000, 1'b1);
        send_number(32'h0000_0009, 1'b0);
        // unused sign mode behaves as no sign
        set_format(BASE_DEC, 1'b0, 1'b0, SIGN_UNUSED, 1'b0, 1'b0, 7'd0, 6'd0);
        send_number(32'h0000_0000, 1'b0);
        set_format(BASE_DEC, 1'b0, 1'b0, SIGN_SPACE, 1'b0, 1'b0, 7'd0, 6'd0);
        send_number(32'h0000_0000, 1'b0);
    endtask

    task automatic test_padding();
        // left justify wins over zero padding
        set_format(BASE_DEC, 1'b0, 1'b1, SIGN_PLUS, 1'b0, 1'b1, 7'd20, 6'd1);
        send_number(32'd42, 1'b0);
        send_number(32'hFFFF_FFD6, 1'b1);
        set_format(BASE_DEC, 1'b0, 1'b0, SIGN_NONE, 1'b0, 1'b0, 7'd8, 6'd3);
        send_number(32'd5, 1'b0);
    endtask

    task automatic test_saturation();
        set_format(BASE_HEX, 1'b0, 1'b0, SIGN_SPACE, 1'b1, 1'b1, 7'd127, 6'd63);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h0000_1234, 1'b0);
        set_format(BASE_BIN, 1'b1, 1'b0, SIGN_PLUS, 1'b1, 1'b1, 7'd64, 6'd61);
        send_number(32'hFFFF_FFFF, 1'b0);
        set_format(BASE_OCT, 1'b0, 1'b1, SIGN_NONE, 1'b0, 1'b1, 7'd127, 6'd0);
        send_number(32'h0000_0000, 1'b0);
    endtask

    task automatic test_random();
        logic [6:0] fw;
        logic [5:0] md;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            fw = ($urandom_range(5) == 0) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(24));
            md = ($urandom_range(5) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(12));
            // pin the width and precision extremes on the first phases
            if (phase == 0)
            begin
                fw = 7'd127;
                md = 6'd63;
            end
            else if (phase == 1)
            begin
                fw = 7'd0;
                md = 6'd0;
            end
            else if (phase == 2)
            begin
                fw = 7'd64;
                md = 6'd61;
            end
            set_format(2'($urandom_range(3)), 1'($urandom_range(1)), ($urandom_range(2) == 0),
                       2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       fw, md);
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 48;
                default: idle_pct = 29;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_number(random_value(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        fmt.base_select  = BASE_DEC;
        fmt.upper_case   = 1'b0;
        fmt.left_justify = 1'b0;
        fmt.sign_mode    = SIGN_NONE;
        fmt.alt_form     = 1'b0;
        fmt.zero_fill    = 1'b0;
        fmt.field_width  = 7'd0;
        fmt.min_digits   = 6'd1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_format();
        idle_pct = 48;
        test_radix_and_prefix();
        idle_pct = 0;
        test_zero_and_empty();
        test_padding();
        test_saturation();
        test_random();

        wait_idle();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/itf_pkg.sv
rtl/itf_cfg_regs.sv
rtl/itf_digit_conv.sv
rtl/integer_to_text_formatter.sv
tb/tb_top.sv
